### hw/rtl/msf_tsd_pkg.sv
// ----------------------------------------------------------------------------
// MSF time signal decoder package
// Shared types, register indexes and constants of the decoder.
// ----------------------------------------------------------------------------
package msf_tsd_pkg;

   // configuration port
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDTH_TOLERANCE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFF_WIDTH_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IGNORE_WIDTH     = 2'd2;

   localparam logic [7:0] WIDTH_TOLERANCE_RESET  = 8'd30;
   localparam logic [7:0] OFF_WIDTH_OFFSET_RESET = 8'd20;
   localparam logic [7:0] IGNORE_WIDTH_RESET     = 8'd30;

   // nominal carrier-off widths, ms
   localparam logic [9:0] NOMINAL_MARKER = 10'd500;
   localparam logic [9:0] NOMINAL_300    = 10'd300;
   localparam logic [9:0] NOMINAL_200    = 10'd200;
   localparam logic [9:0] NOMINAL_100    = 10'd100;

   // carrier-on windows, ms
   localparam logic [31:0] ON_SHORT_MIN  = 32'd5;
   localparam logic [31:0] ON_SHORT_MAX  = 32'd200;
   localparam logic [31:0] ON_NORMAL_MIN = 32'd400;
   localparam logic [10:0] ON_NORMAL_MAX = 11'd900;

   // frame store
   localparam int FRAME_BITS = 60;
   localparam int POS_WIDTH  = 6;

   // BCD weights, lowest digit bit first
   localparam logic [6:0] BCD_WEIGHT [8] = '{7'd1, 7'd2, 7'd4, 7'd8,
                                            7'd10, 7'd20, 7'd40, 7'd80};

   // pulse queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = 2;
   localparam int QCOUNT_WIDTH = 3;

   typedef struct packed {
      logic [7:0] width_tolerance;
      logic [7:0] off_width_offset;
      logic [7:0] ignore_width;
   } cfg_type;

   // one classified pulse
   typedef struct packed {
      logic is500;
      logic is300;
      logic is200;
      logic is100;
      logic on_short;
      logic on_normal;
   } pulse_type;

   // one decoded frame
   typedef struct packed {
      logic        time_valid;
      logic [7:0]  year;
      logic [4:0]  month;
      logic [5:0]  day_of_month;
      logic [2:0]  day_of_week;
      logic [5:0]  hour;
      logic [6:0]  minute;
      logic [15:0] good_pulse_count;
   } time_type;

endpackage

### hw/rtl/msf_tsd_if.sv
// ----------------------------------------------------------------------------
// MSF time signal decoder channels
// Edge request channel and decoded time response channel.
// ----------------------------------------------------------------------------
interface msf_tsd_req_if;
   logic        valid;
   logic        ready;
   logic        carrier_off;
   logic [31:0] time_ms;

   modport source (output valid, carrier_off, time_ms, input ready);
   modport sink   (input valid, carrier_off, time_ms, output ready);
endinterface

interface msf_tsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        time_valid;
   logic [7:0]  year;
   logic [4:0]  month;
   logic [5:0]  day_of_month;
   logic [2:0]  day_of_week;
   logic [5:0]  hour;
   logic [6:0]  minute;
   logic [15:0] good_pulse_count;

   modport source (output valid, time_valid, year, month, day_of_month, day_of_week,
                   hour, minute, good_pulse_count, input ready);
   modport sink   (input valid, time_valid, year, month, day_of_month, day_of_week,
                   hour, minute, good_pulse_count, output ready);
endinterface

### hw/rtl/msf_tsd_front.sv
// ----------------------------------------------------------------------------
// MSF decoder front end
// Tracks edge timestamps, drops glitches and classifies pulse widths.
// ----------------------------------------------------------------------------
module msf_tsd_front
   import msf_tsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   msf_tsd_req_if.sink req_ch,
   input  cfg_type   cfg,
   output logic      push_valid,
   output pulse_type push_data,
   input  logic      push_ready
);

   // |w - nom| < margin, w signed
   function automatic logic near_width(input logic [31:0] w, input logic [9:0] nom,
                                       input logic [7:0] margin);
      logic [32:0] diff;
      logic [32:0] mag;
      diff = {w[31], w} - {23'd0, nom};
      mag  = diff[32] ? (33'd0 - diff) : diff;
      return mag < {25'd0, margin};
   endfunction

   logic [31:0] off_start_ff, off_start_in;
   logic [31:0] on_start_ff, on_start_in;
   logic [31:0] prev_off_ff, prev_off_in;
   logic [31:0] prev_on_ff, prev_on_in;
   logic [31:0] last_on_width_ff, last_on_width_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_off_width_ff, s1_off_width_in;
   logic        s1_on_short_ff, s1_on_short_in;
   logic        s1_on_normal_ff, s1_on_normal_in;

   logic        req_fire;
   logic [31:0] now;
   logic [31:0] since_on;
   logic [31:0] since_off;
   logic [31:0] ignore_limit;
   logic        glitch_off;
   logic        glitch_on;
   logic [10:0] normal_max;

   assign now      = req_ch.time_ms;
   assign req_ch.ready = !s1_valid_ff || push_ready;
   assign req_fire = req_ch.valid && req_ch.ready;

   // edge spacing, signed modulo 2^32
   assign since_on     = now - on_start_ff;
   assign since_off    = now - off_start_ff;
   assign ignore_limit = {24'd0, cfg.ignore_width};
   assign glitch_off   = $signed(since_on) < $signed(ignore_limit);
   assign glitch_on    = $signed(since_off) < $signed(ignore_limit);
   assign normal_max   = ON_NORMAL_MAX + {3'd0, cfg.width_tolerance};

   // timestamp bookkeeping
   always_comb begin
      off_start_in     = off_start_ff;
      on_start_in      = on_start_ff;
      prev_off_in      = prev_off_ff;
      prev_on_in       = prev_on_ff;
      last_on_width_in = last_on_width_ff;
      if (req_fire) begin
         if (req_ch.carrier_off) begin
            if (glitch_off) begin
               on_start_in = prev_on_ff;
            end else begin
               prev_off_in      = off_start_ff;
               off_start_in     = now;
               last_on_width_in = since_on;
            end
         end else begin
            if (glitch_on) begin
               off_start_in = prev_off_ff;
            end else begin
               prev_on_in  = on_start_ff;
               on_start_in = now;
            end
         end
      end
   end

   // stage 1: widths of a carrier-on edge
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_off_width_in = s1_off_width_ff;
      s1_on_short_in  = s1_on_short_ff;
      s1_on_normal_in = s1_on_normal_ff;
      if (req_ch.ready) begin
         s1_valid_in     = req_fire && !req_ch.carrier_off && !glitch_on;
         s1_off_width_in = since_off - {{24{cfg.off_width_offset[7]}}, cfg.off_width_offset};
         s1_on_short_in  = ($signed(last_on_width_ff) > $signed(ON_SHORT_MIN)) &&
                           ($signed(last_on_width_ff) < $signed(ON_SHORT_MAX));
         s1_on_normal_in = ($signed(last_on_width_ff) > $signed(ON_NORMAL_MIN)) &&
                           ($signed(last_on_width_ff) < $signed({21'd0, normal_max}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_start_ff     <= '0;
         on_start_ff      <= '0;
         prev_off_ff      <= '0;
         prev_on_ff       <= '0;
         last_on_width_ff <= '0;
         s1_valid_ff      <= 1'b0;
      end else begin
         off_start_ff     <= off_start_in;
         on_start_ff      <= on_start_in;
         prev_off_ff      <= prev_off_in;
         prev_on_ff       <= prev_on_in;
         last_on_width_ff <= last_on_width_in;
         s1_valid_ff      <= s1_valid_in;
      end
      s1_off_width_ff <= s1_off_width_in;
      s1_on_short_ff  <= s1_on_short_in;
      s1_on_normal_ff <= s1_on_normal_in;
   end

   // stage 2: carrier-off width classes into the queue
   assign push_valid          = s1_valid_ff;
   assign push_data.is500     = near_width(s1_off_width_ff, NOMINAL_MARKER, cfg.width_tolerance);
   assign push_data.is300     = near_width(s1_off_width_ff, NOMINAL_300, cfg.width_tolerance);
   assign push_data.is200     = near_width(s1_off_width_ff, NOMINAL_200, cfg.width_tolerance);
   assign push_data.is100     = near_width(s1_off_width_ff, NOMINAL_100, cfg.width_tolerance);
   assign push_data.on_short  = s1_on_short_ff;
   assign push_data.on_normal = s1_on_normal_ff;

endmodule

### hw/rtl/msf_tsd_queue.sv
// ----------------------------------------------------------------------------
// MSF decoder pulse queue
// Short FIFO of classified pulses between front and back end.
// ----------------------------------------------------------------------------
module msf_tsd_queue
   import msf_tsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  pulse_type push_data,
   output logic      push_ready,
   output logic      pop_valid,
   output pulse_type pop_data,
   input  logic      pop_ready
);

   pulse_type                 entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = count_ff != QCOUNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/msf_tsd_back.sv
// ----------------------------------------------------------------------------
// MSF decoder back end
// Assembles A/B bit pairs, checks the frame on a minute marker and
// registers the decoded time.
// ----------------------------------------------------------------------------
module msf_tsd_back
   import msf_tsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   input  pulse_type pop_data,
   output logic      pop_ready,
   msf_tsd_rsp_if.source rsp_ch
);

   // BCD value of A bits first..last, bit last weighs 1
   function automatic logic [7:0] bcd_field(input logic [FRAME_BITS-1:0] a,
                                            input int first, input int last);
      logic [7:0] sum;
      sum = '0;
      for (int k = 0; k < 8; k++) begin
         if ((last - k >= first) && a[last - k]) begin
            sum = sum + {1'b0, BCD_WEIGHT[k]};
         end
      end
      return sum;
   endfunction

   logic [FRAME_BITS-1:0] a_ff, a_in;
   logic [FRAME_BITS-1:0] b_ff, b_in;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                  reading_ff, reading_in;
   logic [15:0]           good_ff, good_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   time_type              result_ff, result_in;

   logic                  take;
   logic                  emit;
   logic                  frame_ok;
   logic                  in_store;
   logic [POS_WIDTH:0]    pos_100;
   logic [POS_WIDTH:0]    pos_200;
   logic [POS_WIDTH:0]    pos_300;
   logic [POS_WIDTH:0]    pos_end;

   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign take      = pop_valid && pop_ready;
   assign in_store  = pos_ff < POS_WIDTH'(FRAME_BITS);

   // count, marker and odd parity checks
   assign frame_ok = (pos_ff == POS_WIDTH'(FRAME_BITS)) && !a_ff[52] && !a_ff[59] &&
                     (&a_ff[58:53]) &&
                     (^{a_ff[24:17], b_ff[54]}) &&
                     (^{a_ff[35:25], b_ff[55]}) &&
                     (^{a_ff[38:36], b_ff[56]}) &&
                     (^{a_ff[51:39], b_ff[57]});

   // positions of the 100, 200 and 300 ms writes in order
   assign pos_100 = {1'b0, pos_ff};
   assign pos_200 = pos_100 + (POS_WIDTH+1)'(pop_data.is100);
   assign pos_300 = pos_200 + (POS_WIDTH+1)'(pop_data.is200);
   assign pos_end = pos_300 + (POS_WIDTH+1)'(pop_data.is300);

   // frame assembly
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      pos_in       = pos_ff;
      reading_in   = reading_ff;
      good_in      = good_ff;
      emit         = 1'b0;
      result_in    = result_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      if (take) begin
         if ((pop_data.on_normal || pop_data.on_short) &&
             (pop_data.is100 || pop_data.is200 || pop_data.is300 || pop_data.is500)) begin
            good_in = (good_ff != 16'hFFFF) ? good_ff + 16'd1 : good_ff;
         end else begin
            good_in = '0;
         end

         if (pop_data.is500) begin
            emit       = reading_ff;
            reading_in = 1'b1;
            pos_in     = POS_WIDTH'(1);
         end else if (reading_ff) begin
            if (in_store && pop_data.on_normal &&
                (pop_data.is100 || pop_data.is200 || pop_data.is300)) begin
               for (int i = 0; i < FRAME_BITS; i++) begin
                  if (pop_data.is100 && pos_100 == (POS_WIDTH+1)'(i)) begin
                     a_in[i] = 1'b0;
                     b_in[i] = 1'b0;
                  end
                  if (pop_data.is200 && pos_200 == (POS_WIDTH+1)'(i)) begin
                     a_in[i] = 1'b1;
                     b_in[i] = 1'b0;
                  end
                  if (pop_data.is300 && pos_300 == (POS_WIDTH+1)'(i)) begin
                     a_in[i] = 1'b1;
                     b_in[i] = 1'b1;
                  end
               end
               pos_in = pos_end[POS_WIDTH-1:0];
            end else if (in_store && pop_data.on_short && pop_data.is100 &&
                         pos_ff != '0) begin
               // short on-time after 100 ms off: B bit of previous second
               b_in[pos_ff - POS_WIDTH'(1)] = 1'b1;
            end else begin
               reading_in = 1'b0;
               pos_in     = '0;
            end
         end

         // decoded time on a minute marker
         if (emit) begin
            rsp_valid_in               = 1'b1;
            result_in                  = '0;
            result_in.time_valid       = frame_ok;
            result_in.good_pulse_count = good_in;
            if (frame_ok) begin
               result_in.year         = bcd_field(a_ff, 17, 24);
               result_in.month        = 5'(bcd_field(a_ff, 25, 29));
               result_in.day_of_month = 6'(bcd_field(a_ff, 30, 35));
               result_in.day_of_week  = 3'(bcd_field(a_ff, 36, 38));
               result_in.hour         = 6'(bcd_field(a_ff, 39, 44));
               result_in.minute       = 7'(bcd_field(a_ff, 45, 51));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         b_ff         <= '0;
         pos_ff       <= '0;
         reading_ff   <= 1'b0;
         good_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         pos_ff       <= pos_in;
         reading_ff   <= reading_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.time_valid       = result_ff.time_valid;
   assign rsp_ch.year             = result_ff.year;
   assign rsp_ch.month            = result_ff.month;
   assign rsp_ch.day_of_month     = result_ff.day_of_month;
   assign rsp_ch.day_of_week      = result_ff.day_of_week;
   assign rsp_ch.hour             = result_ff.hour;
   assign rsp_ch.minute           = result_ff.minute;
   assign rsp_ch.good_pulse_count = result_ff.good_pulse_count;

endmodule

### hw/rtl/msf_time_signal_decoder.sv
// ----------------------------------------------------------------------------
// MSF time signal decoder
// Decodes the MSF time code from receiver edges into date and time words.
//
//   channel   direction  handshake     word
//   req_ch    in         valid/ready   carrier_off, time_ms (one edge)
//   rsp_ch    out        valid/ready   time_valid, date/time, good_pulse_count
//   csr_*     in         write enable  width_tolerance, off_width_offset, ignore_width
//
// One edge is accepted per cycle while req_ch.ready is high. A carrier-on
// edge passes one register in the front end, then a four-entry queue, then
// the frame assembly and the result register in the back end.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds in the output register; the queue keeps edges
// flowing until it fills, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module msf_time_signal_decoder
   import msf_tsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   msf_tsd_req_if.sink                req_ch,
   msf_tsd_rsp_if.source              rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid;
   pulse_type push_data;
   logic      push_ready;
   logic      pop_valid;
   pulse_type pop_data;
   logic      pop_ready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_TOLERANCE:  cfg_in.width_tolerance  = csr_wdata;
            CSR_OFF_WIDTH_OFFSET: cfg_in.off_width_offset = csr_wdata;
            CSR_IGNORE_WIDTH:     cfg_in.ignore_width     = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_tolerance  <= WIDTH_TOLERANCE_RESET;
         cfg_ff.off_width_offset <= OFF_WIDTH_OFFSET_RESET;
         cfg_ff.ignore_width     <= IGNORE_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msf_tsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   msf_tsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   msf_tsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

### hw/rtl/msf_tsd_checker.sv
// ----------------------------------------------------------------------------
// MSF time signal decoder checker
// Port-level assertions, bound to the decoder top level.
// ----------------------------------------------------------------------------
module msf_tsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        time_valid,
   input logic [7:0]  year,
   input logic [4:0]  month,
   input logic [5:0]  day_of_month,
   input logic [2:0]  day_of_week,
   input logic [5:0]  hour,
   input logic [6:0]  minute,
   input logic [15:0] good_pulse_count
);

   // no result word straight out of reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // pipeline is empty after reset, so an edge can be taken
   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready after reset");

   // a failed frame carries no date or time
   a_invalid_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !time_valid |-> year == 8'd0 && month == 5'd0 &&
         day_of_month == 6'd0 && day_of_week == 3'd0 && hour == 6'd0 && minute == 7'd0)
      else $error("invalid frame with nonzero time fields");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(time_valid) && $stable(year) &&
         $stable(month) && $stable(day_of_month) && $stable(day_of_week) &&
         $stable(hour) && $stable(minute) && $stable(good_pulse_count))
      else $error("response word changed while stalled");

endmodule

bind msf_time_signal_decoder msf_tsd_checker u_msf_tsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .time_valid       (rsp_ch.time_valid),
   .year             (rsp_ch.year),
   .month            (rsp_ch.month),
   .day_of_month     (rsp_ch.day_of_month),
   .day_of_week      (rsp_ch.day_of_week),
   .hour             (rsp_ch.hour),
   .minute           (rsp_ch.minute),
   .good_pulse_count (rsp_ch.good_pulse_count)
);

### verif/msf_tsd_time_check.sv
// ----------------------------------------------------------------------------
// MSF time signal decoder checker
// Watches the edge and time channels and the register port, keeps its own
// model of the decoder, and compares every time word with the oldest one
// it predicted. Hands the error count and the number of open words to the top.
// ----------------------------------------------------------------------------
module msf_tsd_time_check
   import msf_tsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   msf_tsd_req_if                     req_ch,
   msf_tsd_rsp_if                     rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         err_count,
   output int                         open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // model copy of the registers and the decoder state
   cfg_type     cfg;
   logic [31:0] fall_stamp;
   logic [31:0] rise_stamp;
   logic [31:0] fall_stamp_prev;
   logic [31:0] rise_stamp_prev;
   logic [31:0] mark_width;
   logic [59:0] a_bits;
   logic [59:0] b_bits;
   logic [5:0]  slot;
   bit          in_frame;
   logic [15:0] run_count;

   time_type    expected_times[$];

   // |w - nominal| strictly inside the margin
   function automatic bit near_nominal(longint w, longint nominal);
      longint d;
      d = w - nominal;
      if (d < 0) d = -d;
      return d < longint'(cfg.width_tolerance);
   endfunction

   // highest-numbered bit of the group carries weight 1
   function automatic int bcd_value(int first, int last);
      int sum;
      sum = 0;
      for (int k = 0; k < 8 && last - k >= first; k++)
         if (a_bits[last-k]) sum += BCD_WEIGHT[k];
      return sum;
   endfunction

   // bit count, marker pattern and the four odd parities
   function automatic bit frame_good();
      if (slot != FRAME_BITS) return 1'b0;
      if (a_bits[52] || a_bits[59]) return 1'b0;
      if (a_bits[58:53] != 6'h3F) return 1'b0;
      if (!(^{a_bits[24:17], b_bits[54]})) return 1'b0;
      if (!(^{a_bits[35:25], b_bits[55]})) return 1'b0;
      if (!(^{a_bits[38:36], b_bits[56]})) return 1'b0;
      if (!(^{a_bits[51:39], b_bits[57]})) return 1'b0;
      return 1'b1;
   endfunction

   // slots 60 to 63 are past the store; only the position moves
   task automatic store_pair(bit a, bit b);
      if (slot < FRAME_BITS) begin
         a_bits[slot] = a;
         b_bits[slot] = b;
      end
      slot = slot + 6'd1;
   endtask

   // one accepted edge; queues a time word on a marker inside a frame
   task automatic decode_edge(input logic off, input logic [31:0] now);
      int          gap;
      int          off_ms;
      int          on_ms;
      logic [31:0] shift;
      bit          c500, c300, c200, c100, on_short, on_normal;
      time_type    word;
      if (off) begin
         gap = now - rise_stamp;
         if (gap < int'(cfg.ignore_width)) begin
            // glitch: undo the carrier-on start before it
            rise_stamp = rise_stamp_prev;
            return;
         end
         fall_stamp_prev = fall_stamp;
         fall_stamp      = now;
         mark_width      = fall_stamp - rise_stamp;
         return;
      end
      gap = now - fall_stamp;
      if (gap < int'(cfg.ignore_width)) begin
         fall_stamp = fall_stamp_prev;
         return;
      end
      rise_stamp_prev = rise_stamp;
      rise_stamp      = now;

      // classify the carrier-off width that just ended
      shift  = {{24{cfg.off_width_offset[7]}}, cfg.off_width_offset};
      off_ms = now - fall_stamp - shift;
      c500   = near_nominal(off_ms, NOMINAL_MARKER);
      c300   = near_nominal(off_ms, NOMINAL_300);
      c200   = near_nominal(off_ms, NOMINAL_200);
      c100   = near_nominal(off_ms, NOMINAL_100);

      // classify the carrier-on width before it
      on_ms     = mark_width;
      on_short  = on_ms > int'(ON_SHORT_MIN) && on_ms < int'(ON_SHORT_MAX);
      on_normal = on_ms > int'(ON_NORMAL_MIN) &&
                  longint'(on_ms) < longint'(ON_NORMAL_MAX) + longint'(cfg.width_tolerance);

      // saturating run of well-formed pulses
      if ((on_normal || on_short) && (c100 || c200 || c300 || c500)) begin
         if (run_count != 16'hFFFF) run_count = run_count + 16'd1;
      end else begin
         run_count = '0;
      end

      if (c500) begin
         if (in_frame) begin
            word            = '0;
            word.time_valid = frame_good();
            if (word.time_valid) begin
               word.year         = 8'(bcd_value(17, 24));
               word.month        = 5'(bcd_value(25, 29));
               word.day_of_month = 6'(bcd_value(30, 35));
               word.day_of_week  = 3'(bcd_value(36, 38));
               word.hour         = 6'(bcd_value(39, 44));
               word.minute       = 7'(bcd_value(45, 51));
            end
            word.good_pulse_count = run_count;
            expected_times.push_back(word);
         end
         in_frame = 1'b1;
         slot     = 6'd1;
      end else if (in_frame) begin
         if (slot < FRAME_BITS && on_normal && (c100 || c200 || c300)) begin
            // overlapping classes each write a pair, in this order
            if (c100) store_pair(1'b0, 1'b0);
            if (c200) store_pair(1'b1, 1'b0);
            if (c300) store_pair(1'b1, 1'b1);
         end else if (slot < FRAME_BITS && on_short && c100 && slot > 0) begin
            // 100 off, 100 on, 100 off: B bit of the previous second
            b_bits[slot-1] = 1'b1;
         end else begin
            in_frame = 1'b0;
            slot     = '0;
         end
      end
   endtask

   task automatic log_error(string why, time_type want, time_type got);
      err_count++;
      if (err_count <= 10)
         $display("%0t %s: exp v=%0d y=%0d mo=%0d d=%0d w=%0d h=%0d mi=%0d n=%0d", $time,
                  why, want.time_valid, want.year, want.month, want.day_of_month,
                  want.day_of_week, want.hour, want.minute, want.good_pulse_count,
                  " | got v=%0d y=%0d mo=%0d d=%0d w=%0d h=%0d mi=%0d n=%0d",
                  got.time_valid, got.year, got.month, got.day_of_month,
                  got.day_of_week, got.hour, got.minute, got.good_pulse_count);
   endtask

   always @(posedge clock) begin
      time_type got;
      time_type want;
      bit       bad;
      if (reset) begin
         cfg.width_tolerance  = WIDTH_TOLERANCE_RESET;
         cfg.off_width_offset = OFF_WIDTH_OFFSET_RESET;
         cfg.ignore_width     = IGNORE_WIDTH_RESET;
         fall_stamp      = '0;
         rise_stamp      = '0;
         fall_stamp_prev = '0;
         rise_stamp_prev = '0;
         mark_width      = '0;
         a_bits          = '0;
         b_bits          = '0;
         slot            = '0;
         in_frame        = 1'b0;
         run_count       = '0;
         expected_times.delete();
      end else begin
         // time word leaving the block
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.time_valid       = rsp_ch.time_valid;
            got.year             = rsp_ch.year;
            got.month            = rsp_ch.month;
            got.day_of_month     = rsp_ch.day_of_month;
            got.day_of_week      = rsp_ch.day_of_week;
            got.hour             = rsp_ch.hour;
            got.minute           = rsp_ch.minute;
            got.good_pulse_count = rsp_ch.good_pulse_count;
            if (expected_times.size() == 0) begin
               log_error("unexpected time word", '0, got);
            end else begin
               want = expected_times.pop_front();
               bad  = (got.time_valid !== want.time_valid) ||
                      (got.year !== want.year) ||
                      (got.month !== want.month) ||
                      (got.day_of_month !== want.day_of_month) ||
                      (got.day_of_week !== want.day_of_week) ||
                      (got.hour !== want.hour) ||
                      (got.minute !== want.minute) ||
                      (got.good_pulse_count !== want.good_pulse_count);
               if (bad) log_error("time word mismatch", want, got);
            end
         end
         // edge word entering the block
         if (req_ch.valid && req_ch.ready) decode_edge(req_ch.carrier_off, req_ch.time_ms);
         // register writes land at the same edge as in the block
         if (csr_we) begin
            case (csr_index)
               CSR_WIDTH_TOLERANCE:  cfg.width_tolerance  = csr_wdata;
               CSR_OFF_WIDTH_OFFSET: cfg.off_width_offset = csr_wdata;
               CSR_IGNORE_WIDTH:     cfg.ignore_width     = csr_wdata;
               default: ;
            endcase
         end
      end
      open_count <= expected_times.size();
   end

endmodule

### verif/tb_msf_time_signal_decoder.sv
// ----------------------------------------------------------------------------
// MSF time signal decoder testbench
// Drives receiver edges shaped as MSF seconds and minute frames, with noise,
// glitches and damaged frames, under several register settings and idle and
// stall patterns. The checker beside the block predicts and compares the
// time words.
// ----------------------------------------------------------------------------
module tb_msf_time_signal_decoder
   import msf_tsd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {FLAW_NONE, FLAW_FLIP, FLAW_LONG, FLAW_SHORT, FLAW_BLIP} flaw_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                         err_count;
   int                         open_count;

   // traffic shaping
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          hold_len  = 0;
   int          words_sent = 0;

   // current register values and the edge time base
   int          cur_margin = 30;
   int          cur_offset = 20;
   logic [31:0] ms_now;

   msf_tsd_req_if edge_ch ();
   msf_tsd_rsp_if time_ch ();

   msf_time_signal_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (edge_ch),
      .rsp_ch    (time_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   msf_tsd_time_check i_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (edge_ch),
      .rsp_ch     (time_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .err_count  (err_count),
      .open_count (open_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         time_ch.ready <= 1'b0;
      end else if (hold_len != 0) begin
         time_ch.ready <= 1'b0;
         hold_len      <= hold_len - 1;
      end else begin
         time_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #400_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one edge word, after a random gap; returns at the accepting edge
   task automatic offer_edge(input logic off, input logic [31:0] stamp);
      while ($urandom_range(99) < idle_pct) begin
         edge_ch.valid <= 1'b0;
         @(posedge clock);
      end
      edge_ch.valid       <= 1'b1;
      edge_ch.carrier_off <= off;
      edge_ch.time_ms     <= stamp;
      @(posedge clock);
      while (!edge_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // sender pauses until every time word is out, then the pipe settles
   task automatic wait_quiet();
      edge_ch.valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(int margin, int offset, int glitch_ms);
      cur_margin = margin;
      cur_offset = offset;
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH_TOLERANCE;
      csr_wdata <= margin[7:0];
      @(posedge clock);
      csr_index <= CSR_OFF_WIDTH_OFFSET;
      csr_wdata <= offset[7:0];
      @(posedge clock);
      csr_index <= CSR_IGNORE_WIDTH;
      csr_wdata <= glitch_ms[7:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // timing error kept inside the margin so clean pulses still classify
   function automatic int jitter_ms();
      int span;
      span = (cur_margin > 1) ? cur_margin - 1 : 0;
      if (span > 8) span = 8;
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int normal_on();
      return $urandom_range(850, 450);
   endfunction

   function automatic int short_on();
      return $urandom_range(150, 60);
   endfunction

   // brief off-on pair, at most 3 ms apart
   task automatic glitch_blip();
      offer_edge(1'b1, ms_now);
      ms_now += $urandom_range(3);
      offer_edge(1'b0, ms_now);
   endtask

   // carrier off for the nominal width plus offset, then carrier on
   task automatic second_pulse(int nominal, int on_len, bit blip);
      int dur;
      int part;
      dur = nominal + cur_offset + jitter_ms();
      offer_edge(1'b1, ms_now);
      ms_now += dur;
      offer_edge(1'b0, ms_now);
      if (blip) begin
         part = $urandom_range(300, 60);
         ms_now += part;
         glitch_blip();
         on_len = (on_len - part < 60) ? 60 : on_len - part;
      end
      ms_now += on_len;
   endtask

   task automatic send_marker();
      second_pulse(int'(NOMINAL_MARKER), normal_on(), 1'b0);
   endtask

   // one second of the code: A and B bit pair
   task automatic send_bit(bit a, bit b, bit blip);
      if (a && b) begin
         second_pulse(int'(NOMINAL_300), normal_on(), blip);
      end else if (a) begin
         second_pulse(int'(NOMINAL_200), normal_on(), blip);
      end else if (b) begin
         second_pulse(int'(NOMINAL_100), short_on(), 1'b0);
         second_pulse(int'(NOMINAL_100), normal_on(), blip);
      end else begin
         second_pulse(int'(NOMINAL_100), normal_on(), blip);
      end
   endtask

   // marker and 59 seconds of random date, correct markers and parity, then the flaw if any
   task automatic send_frame(flaw_type flaw);
      logic [59:0] a;
      logic [59:0] b;
      int          extra;
      int          skip;
      int          blip_at;
      int          idx;
      a = 60'({$urandom, $urandom});
      b = 60'({$urandom, $urandom});
      a[52]    = 1'b0;
      a[58:53] = 6'h3F;
      a[59]    = 1'b0;
      b[54]    = ~^a[24:17];
      b[55]    = ~^a[35:25];
      b[56]    = ~^a[38:36];
      b[57]    = ~^a[51:39];
      if (flaw == FLAW_FLIP) begin
         idx    = $urandom_range(59, 17);
         a[idx] = ~a[idx];
      end
      extra   = (flaw == FLAW_LONG) ? $urandom_range(4, 1) : 0;
      skip    = (flaw == FLAW_SHORT) ? $urandom_range(59, 1) : -1;
      blip_at = (flaw == FLAW_BLIP) ? $urandom_range(59, 1) : -1;
      send_marker();
      for (int s = 1; s < FRAME_BITS + extra; s++) begin
         if (s == skip) continue;
         send_bit(a[s % FRAME_BITS], b[s % FRAME_BITS], s == blip_at);
      end
   endtask

   // random edges: any time, small steps, steps back, and marker runs
   task automatic send_noise(int count);
      int kind;
      repeat (count) begin
         kind = $urandom_range(3);
         case (kind)
            0: offer_edge(1'($urandom_range(1)), $urandom);
            1: begin
               ms_now += $urandom_range(700);
               offer_edge(1'($urandom_range(1)), ms_now);
            end
            2: begin
               ms_now -= $urandom_range(40);
               offer_edge(1'($urandom_range(1)), ms_now);
            end
            default: send_marker();
         endcase
      end
   endtask

   initial begin
      int phase_start;
      int pick;
      edge_ch.valid       = 1'b0;
      edge_ch.carrier_off = 1'b0;
      edge_ch.time_ms     = '0;
      time_ch.ready       = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_WIDTH_TOLERANCE;
      csr_wdata           = '0;
      ms_now              = 32'h7FFF_F000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme stamps, negative and zero gaps, back-to-back
      // markers, all four bit pairs, a glitch, and a short frame
      offer_edge(1'b1, 32'hFFFF_FFFF);
      offer_edge(1'b0, 32'h0000_0000);
      send_marker();
      send_marker();
      send_bit(1'b0, 1'b0, 1'b0);
      send_bit(1'b1, 1'b0, 1'b0);
      send_bit(1'b1, 1'b1, 1'b0);
      send_bit(1'b0, 1'b1, 1'b0);
      glitch_blip();
      send_marker();
      wait_quiet();

      // random phases over settings and traffic patterns
      for (int p = 0; p < 7; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         case (p)
            0: apply_settings(30, 20, 30);
            1: apply_settings(0, -128, 0);
            2: apply_settings(255, 127, 255);
            3: begin
               apply_settings(150, 20, 30);
               ms_now = 32'hFFFF_C000;
            end
            4: apply_settings(8, 0, 1);
            6: apply_settings(45, -20, 60);
            default: apply_settings($urandom_range(60, 5), int'($urandom_range(90)) - 30,
                                    $urandom_range(90));
         endcase
         phase_start = words_sent;
         while (words_sent - phase_start < 120) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
               pick = $urandom_range(9);
               send_frame(pick < 6 ? FLAW_NONE : flaw_type'(pick - 5));
            end else begin
               send_noise($urandom_range(16, 4));
            end
         end
         send_marker();
         if (p == 0) begin
            // receiver holds off while markers keep producing words
            hold_len <= 300;
            repeat (40) send_marker();
         end
         wait_quiet();
      end

      if (err_count == 0 && open_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
